// ----- src/clcd_pkg.sv -----
// shared types, codes and constants of the character lcd command sequencer
`default_nettype none

package clcd_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_SWAP   = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    // job kinds carried from the front to the back
    localparam logic [1:0] JOB_INIT = 2'd0;
    localparam logic [1:0] JOB_ONE  = 2'd1;
    localparam logic [1:0] JOB_TWO  = 2'd2;

    // register map
    localparam logic [2:0] ADDR_EXPANDER    = 3'd0;
    localparam logic [6:0] EXPANDER_DEFAULT = 7'h27;

    // display geometry
    localparam int unsigned COLUMNS_PER_ROW = 16;
    localparam int unsigned SECOND_ROW_BASE = 64;

    // lcd commands
    localparam logic [7:0] CMD_FUNC_8BIT = 8'h30;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h20;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_DISPLAY   = 8'h0F;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    // number of lcd bytes in the power-up sequence, minus one
    localparam logic [2:0] INIT_LAST_TXN = 3'd5;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       second_rs;
    } job_t;

    // lcd byte of the power-up sequence at a given transaction
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0, 3'd1, 3'd2: cmd = CMD_FUNC_8BIT;
            3'd3:             cmd = CMD_FUNC_4BIT;
            3'd4:             cmd = CMD_CLEAR;
            default:          cmd = CMD_DISPLAY;
        endcase
        return cmd;
    endfunction

    // set-address command for a row and column
    function automatic logic [7:0] cursor_cmd(input logic row, input logic [5:0] col);
        logic [7:0] base;
        base = row ? 8'(SECOND_ROW_BASE) : 8'd0;
        return CMD_SET_DDRAM | (base + {2'b00, col});
    endfunction

endpackage

`default_nettype wire

// ----- src/clcd_front.sv -----
// front end: accepts operations, keeps cursor state and builds jobs
`default_nettype none

module clcd_front
    import clcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic       queue_full,
    input  wire logic [2:0] opcode,
    input  wire logic [7:0] char_value,
    input  wire logic       target_row,
    input  wire logic [5:0] target_column,
    output logic            push,
    output job_t            job
);

    logic       active_row_reg;
    logic       active_row_next;
    logic [4:0] top_col_reg;
    logic [4:0] top_col_next;
    logic [4:0] bot_col_reg;
    logic [4:0] bot_col_next;
    logic       accept;
    logic [4:0] cur_col;
    logic       wrap;
    logic       flip_row;
    logic [4:0] flip_col;

    assign accept   = item_valid && !queue_full;
    assign cur_col  = active_row_reg ? bot_col_reg : top_col_reg;
    assign wrap     = cur_col >= 5'(COLUMNS_PER_ROW);
    assign flip_row = !active_row_reg;
    assign flip_col = flip_row ? bot_col_reg : top_col_reg;

    // classify the operation and work out the next cursor state
    always_comb
    begin
        active_row_next = active_row_reg;
        top_col_next    = top_col_reg;
        bot_col_next    = bot_col_reg;
        push            = 1'b0;
        job.kind        = JOB_ONE;
        job.first_byte  = 8'd0;
        job.second_byte = 8'd0;
        job.second_rs   = 1'b0;
        unique case (opcode)
            OP_INIT:
            begin
                push            = 1'b1;
                job.kind        = JOB_INIT;
                active_row_next = 1'b0;
                top_col_next    = 5'd0;
                bot_col_next    = 5'd0;
            end
            OP_CLEAR:
            begin
                push            = 1'b1;
                job.second_byte = CMD_CLEAR;
                active_row_next = 1'b0;
                top_col_next    = 5'd0;
                bot_col_next    = 5'd0;
            end
            OP_WRITE:
            begin
                push            = 1'b1;
                job.second_byte = char_value;
                job.second_rs   = 1'b1;
                if (wrap)
                begin
                    job.kind        = JOB_TWO;
                    job.first_byte  = cursor_cmd(flip_row, 6'd0);
                    active_row_next = flip_row;
                    top_col_next    = flip_row ? 5'd0 : 5'd1;
                    bot_col_next    = flip_row ? 5'd1 : 5'd0;
                end
                else if (active_row_reg)
                begin
                    bot_col_next = bot_col_reg + 5'd1;
                end
                else
                begin
                    top_col_next = top_col_reg + 5'd1;
                end
            end
            OP_SWAP:
            begin
                push            = 1'b1;
                job.second_byte = cursor_cmd(flip_row, {1'b0, flip_col});
                active_row_next = flip_row;
            end
            OP_CURSOR:
            begin
                push            = 1'b1;
                job.second_byte = cursor_cmd(target_row, target_column);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        if (!accept)
        begin
            push = 1'b0;
        end
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_row_reg <= 1'b0;
            top_col_reg    <= 5'd0;
            bot_col_reg    <= 5'd0;
        end
        else if (accept)
        begin
            active_row_reg <= active_row_next;
            top_col_reg    <= top_col_next;
            bot_col_reg    <= bot_col_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/clcd_queue.sv -----
// short job queue between the front end and the byte sequencer
`default_nettype none

module clcd_queue
    import clcd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- src/clcd_back.sv -----
// back end: expands each job into expander bytes, one per cycle while byte_stall is low
`default_nettype none

module clcd_back
    import clcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire job_t       job,
    output logic            pop,
    output logic            byte_valid,
    input  wire logic       byte_stall,
    output logic [7:0]      bus_byte,
    output logic            end_of_transfer,
    output logic            last
);

    logic [2:0] txn_reg;
    logic [1:0] nib_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_eot_reg;
    logic       out_last_reg;
    logic       load;
    logic [7:0] lcd_byte;
    logic       lcd_rs;
    logic [2:0] final_txn;
    logic [3:0] nibble;
    logic       eot;
    logic       job_done;
    logic [7:0] expander_byte;

    // pick the lcd byte of the current transaction
    always_comb
    begin
        unique case (job.kind)
            JOB_INIT:
            begin
                lcd_byte  = init_cmd(txn_reg);
                lcd_rs    = 1'b0;
                final_txn = INIT_LAST_TXN;
            end
            JOB_TWO:
            begin
                lcd_byte  = (txn_reg == 3'd0) ? job.first_byte : job.second_byte;
                lcd_rs    = (txn_reg == 3'd0) ? 1'b0 : job.second_rs;
                final_txn = 3'd1;
            end
            default:
            begin
                lcd_byte  = job.second_byte;
                lcd_rs    = job.second_rs;
                final_txn = 3'd0;
            end
        endcase
    end

    // high nibble first, each nibble strobed with e high then e low
    assign nibble        = nib_reg[1] ? lcd_byte[3:0] : lcd_byte[7:4];
    assign expander_byte = {nibble, 1'b1, !nib_reg[0], 1'b0, lcd_rs};
    assign eot           = nib_reg == 2'd3;
    assign job_done      = eot && (txn_reg == final_txn);
    assign load          = job_valid && (!out_valid_reg || !byte_stall);
    assign pop           = load && job_done;

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_reg       <= 3'd0;
            nib_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                nib_reg       <= nib_reg + 2'd1;
                out_valid_reg <= 1'b1;
                if (job_done)
                begin
                    txn_reg <= 3'd0;
                end
                else if (eot)
                begin
                    txn_reg <= txn_reg + 3'd1;
                end
            end
            else if (!byte_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= expander_byte;
            out_eot_reg  <= eot;
            out_last_reg <= job_done;
        end
    end

    assign byte_valid      = out_valid_reg;
    assign bus_byte        = out_byte_reg;
    assign end_of_transfer = out_eot_reg;
    assign last            = out_last_reg;

endmodule

`default_nettype wire

// ----- src/char_lcd_i2c_command_sequencer.sv -----
// top level of the character lcd command sequencer over an i2c port expander
// an operation's first expander byte passes through the job queue, then the output register
// throughput: one expander byte per cycle while byte_stall is low; an operation takes 4,
// 8 or 24 expander bytes, while the job queue lets new operations be taken each cycle
// until it fills
// reset: asynchronous active low; clears cursor state, the queue and the output,
// and sets the expander address to 0x27
`default_nettype none

module char_lcd_i2c_command_sequencer
    import clcd_pkg::*;
#(
    parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // operation channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  char_value,
    input  wire logic        target_row,
    input  wire logic [5:0]  target_column,
    // expander byte channel
    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       bus_byte,
    output logic             end_of_transfer,
    output logic             last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [6:0] expander_address_reg;
    logic       queue_full;
    logic       push;
    job_t       push_job;
    logic       pop;
    logic       head_valid;
    job_t       head_job;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_EXPANDER) ? {25'd0, expander_address_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expander_address_reg <= EXPANDER_DEFAULT;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_EXPANDER))
        begin
            expander_address_reg <= pwdata[6:0];
        end
    end

    assign item_stall = queue_full;

    clcd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .queue_full    (queue_full),
        .opcode        (opcode),
        .char_value    (char_value),
        .target_row    (target_row),
        .target_column (target_column),
        .push          (push),
        .job           (push_job)
    );

    clcd_queue #(
        .DEPTH (QUEUE_ENTRIES)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    clcd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (head_valid),
        .job             (head_job),
        .pop             (pop),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .bus_byte        (bus_byte),
        .end_of_transfer (end_of_transfer),
        .last            (last)
    );

    // an operation always ends on a complete transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && last) |-> end_of_transfer)
        else $error("last byte not at end of a transaction");

    // backlight stays on and rw stays low on every byte
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> (bus_byte[3] && !bus_byte[1]))
        else $error("backlight or rw bit wrong");

    // the closing byte of a transaction drops the enable strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && end_of_transfer) |-> !bus_byte[2])
        else $error("enable high on closing byte");

    // a job is only popped when the sequencer had one to work on
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire
